// File: sv/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
// No dependencies; the including module must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/plid_pkg.sv
// Shared constants, codes and controller/datapath interface types for the list store.
// No dependencies.
package plid_pkg;

	// Storage geometry.
	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int VAL_W    = 32;

	// Request function codes.
	localparam logic [2:0] FN_READ      = 3'd0;
	localparam logic [2:0] FN_INS_FRONT = 3'd1;
	localparam logic [2:0] FN_INS_END   = 3'd2;
	localparam logic [2:0] FN_INS_POS   = 3'd3;
	localparam logic [2:0] FN_DELETE    = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Read value reported when nothing was read.
	localparam logic [VAL_W-1:0] NO_VALUE = '1;

	// Source of the memory read address.
	typedef enum logic [1:0] {
		RD_POS  = 2'd0,
		RD_PREV = 2'd1,
		RD_NEXT = 2'd2
	} rd_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       latch_req;
		logic       init_ins;
		logic       init_del;
		logic       idx_inc;
		logic       idx_dec;
		logic       ram_re;
		rd_sel_t    rd_sel;
		logic       ram_we;
		logic       wr_put;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_set;
		logic [1:0] res_status;
		logic       res_found;
	} plid_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] func;
		logic       pos_lt_count;
		logic       ins_range;
		logic       full;
		logic       ins_more;
		logic       del_more;
	} plid_sts_t;

endpackage

// File: sv/positional_list_insert_delete.sv
// Top level of the positional list store: controller plus datapath and port checks.
// Depends on plid_pkg, plid_ctrl, plid_datapath and assert_macros.svh.
//
// A request is taken when start is high and busy is low; its result appears
// on the result ports for exactly one cycle with done high, and the receiver
// cannot hold it off. Entries sit in a single-port-write, single-port-read
// memory, so inserts and deletes move one entry at a time, with a read state
// and a write state per entry. Busy stays high after the transfer while the
// controller decides the request, while a read waits for memory data, and
// while an insert shifts entries up toward the insertion point or a delete
// shifts later entries down over the position. Done is shown in the first
// cycle with busy low, and the next request may be taken in that same cycle.
// Length changes only when an insert or a delete finishes.
module positional_list_insert_delete (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         func,
	input  logic [6:0]         position,
	input  logic signed [31:0] value,
	output logic               done,
	output logic signed [31:0] read_value,
	output logic               found,
	output logic [1:0]         status,
	output logic [6:0]         length
);
	import plid_pkg::*;

	plid_cmd_t cmd;
	plid_sts_t sts;

	plid_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	plid_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (func),
		.position  (position),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.read_value(read_value),
		.found     (found),
		.status    (status),
		.length    (length)
	);

	// Checks on the block's own bookkeeping.
	`include "assert_macros.svh"

	`PLID_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted transfer must hold busy")
	`PLID_ASSERT_NOW(a_len_cap, done, length <= 7'(CAPACITY), "length above capacity")
	`PLID_ASSERT_NOW(a_found_ok, done && found, status == ST_DONE, "found with error status")
	`PLID_ASSERT_NOW(a_full_len, done && status == ST_FULL, length == 7'(CAPACITY), "full while not at capacity")

endmodule

// File: sv/plid_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module plid_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port with output register.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/plid_ctrl.sv
// Controller state machine for the list store: decodes requests and sequences shifts.
// Depends on plid_pkg.
module plid_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  plid_pkg::plid_sts_t sts,
	output plid_pkg::plid_cmd_t cmd
);
	import plid_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECIDE = 7'b0000010,
		S_RDWAIT = 7'b0000100,
		S_INSRD  = 7'b0001000,
		S_INSWR  = 7'b0010000,
		S_DELRD  = 7'b0100000,
		S_DELWR  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.rd_sel     = RD_POS;
		cmd.res_status = ST_DONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch_req = 1'b1;
					state_d       = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (sts.func) inside
					FN_READ: begin
						if (sts.pos_lt_count) begin
							cmd.ram_re = 1'b1;
							cmd.rd_sel = RD_POS;
							state_d    = S_RDWAIT;
						end else begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_RANGE;
							state_d        = S_IDLE;
						end
					end
					FN_INS_FRONT, FN_INS_END, FN_INS_POS: begin
						if (sts.ins_range) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_RANGE;
							state_d        = S_IDLE;
						end else if (sts.full) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_FULL;
							state_d        = S_IDLE;
						end else begin
							cmd.init_ins = 1'b1;
							state_d      = S_INSRD;
						end
					end
					FN_DELETE: begin
						if (sts.pos_lt_count) begin
							cmd.init_del = 1'b1;
							state_d      = S_DELRD;
						end else begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_RANGE;
							state_d        = S_IDLE;
						end
					end
					default: begin
						// Unused codes change nothing and report done.
						cmd.res_set = 1'b1;
						state_d     = S_IDLE;
					end
				endcase
			end
			S_RDWAIT: begin
				cmd.res_set   = 1'b1;
				cmd.res_found = 1'b1;
				state_d       = S_IDLE;
			end
			S_INSRD: begin
				if (sts.ins_more) begin
					cmd.ram_re = 1'b1;
					cmd.rd_sel = RD_PREV;
					state_d    = S_INSWR;
				end else begin
					// Gap is open: place the new value and grow the list.
					cmd.ram_we  = 1'b1;
					cmd.wr_put  = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.res_set = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_INSWR: begin
				cmd.ram_we  = 1'b1;
				cmd.idx_dec = 1'b1;
				state_d     = S_INSRD;
			end
			S_DELRD: begin
				if (sts.del_more) begin
					cmd.ram_re = 1'b1;
					cmd.rd_sel = RD_NEXT;
					state_d    = S_DELWR;
				end else begin
					cmd.cnt_dec = 1'b1;
					cmd.res_set = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_DELWR: begin
				cmd.ram_we  = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_DELRD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: sv/plid_datapath.sv
// Datapath for the list store: request registers, cursors, entry memory and result registers.
// Depends on plid_pkg and plid_ram.
module plid_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [2:0]                func,
	input  logic [6:0]                position,
	input  logic signed [31:0]        value,
	input  plid_pkg::plid_cmd_t       cmd,
	output plid_pkg::plid_sts_t       sts,
	output logic                      done,
	output logic signed [31:0]        read_value,
	output logic                      found,
	output logic [1:0]                status,
	output logic [6:0]                length
);
	import plid_pkg::*;

	logic [2:0]       func_q;
	logic [CNT_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] at_q, at_c;
	logic [CNT_W-1:0] idx_q, idx_m1, idx_p1;
	logic [CNT_W:0]   idx_p1_w;
	logic [IDX_W-1:0] ram_raddr, ram_waddr;
	logic [VAL_W-1:0] ram_wdata, ram_rdata;
	logic             done_q, found_q;
	logic [VAL_W-1:0] read_value_q;
	logic [1:0]       status_q;
	logic [CNT_W-1:0] length_q;

	// Request registers, loaded on an accepted transfer.
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			func_q <= func;
			pos_q  <= position;
			val_q  <= value;
		end
	end

	// Insertion point for the three insert kinds.
	always_comb begin
		case (func_q)
			FN_INS_FRONT: at_c = '0;
			FN_INS_END:   at_c = count_q;
			default:      at_c = pos_q;
		endcase
	end

	assign idx_m1   = idx_q - CNT_W'(1);
	assign idx_p1_w = {1'b0, idx_q} + (CNT_W+1)'(1);
	assign idx_p1   = idx_p1_w[CNT_W-1:0];

	// Cursors: insertion point and shift index.
	always_ff @(posedge clk) begin
		if (cmd.init_ins) begin
			at_q  <= at_c;
			idx_q <= count_q;
		end else if (cmd.init_del) begin
			idx_q <= pos_q;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_p1;
		end else if (cmd.idx_dec) begin
			idx_q <= idx_m1;
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.func         = func_q;
		sts.pos_lt_count = (pos_q < count_q);
		sts.ins_range    = (at_c > count_q);
		sts.full         = (count_q == CNT_W'(CAPACITY));
		sts.ins_more     = (idx_q > at_q);
		sts.del_more     = (idx_p1_w < {1'b0, count_q});
	end

	// Memory address and data selection.
	always_comb begin
		case (cmd.rd_sel)
			RD_PREV: ram_raddr = idx_m1[IDX_W-1:0];
			RD_NEXT: ram_raddr = idx_p1[IDX_W-1:0];
			default: ram_raddr = pos_q[IDX_W-1:0];
		endcase
		ram_waddr = cmd.wr_put ? at_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
		ram_wdata = cmd.wr_put ? val_q : ram_rdata;
	end

	plid_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(VAL_W)
	) u_ram (
		.clk  (clk),
		.we   (cmd.ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Length after this request.
	always_comb begin
		count_d = count_q;
		if (cmd.cnt_inc) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.cnt_dec) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= cmd.res_set;
		end
	end

	// Result registers, loaded on the result strobe and held until the next one.
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			read_value_q <= cmd.res_found ? ram_rdata : NO_VALUE;
			found_q      <= cmd.res_found;
			status_q     <= cmd.res_status;
			length_q     <= count_d;
		end
	end

	assign done       = done_q;
	assign read_value = read_value_q;
	assign found      = found_q;
	assign status     = status_q;
	assign length     = length_q;

endmodule
